// ===== sv/acfb_pkg.sv =====
package acfb_pkg;

    // One input transaction: a 16-byte block, its valid byte count and a restart flag.
    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  valid_bytes;
        logic        restart;
    } acfb_req_t;

    // One result transaction.
    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_bytes;
    } acfb_rsp_t;

    typedef logic [2:0] acfb_cfg_index_t;

    localparam acfb_cfg_index_t CFG_KEY_HIGH     = 3'd0;
    localparam acfb_cfg_index_t CFG_KEY_LOW      = 3'd1;
    localparam acfb_cfg_index_t CFG_IV_HIGH      = 3'd2;
    localparam acfb_cfg_index_t CFG_IV_LOW       = 3'd3;
    localparam acfb_cfg_index_t CFG_DECRYPT_MODE = 3'd4;

    localparam int unsigned NUM_ROUNDS = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } acfb_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // Multiply by x in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== sv/acfb_round.sv =====
// One AES-128 round plus one step of the key schedule. Byte i of a 128-bit
// word sits in bits 127-8i down to 120-8i; byte index is 4 * column + row.
module acfb_round (
    input  logic [127:0] blk,
    input  logic [127:0] rkey,
    input  logic [7:0]   rcon,
    input  logic         last,
    output logic [127:0] blk_out,
    output logic [127:0] rkey_out
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] k [16];
    logic [7:0] kn [16];
    logic [7:0] g [4];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8 * i -: 8];
            k[i] = rkey[127 - 8 * i -: 8];
        end

        // SubBytes with ShiftRows folded into the read index.
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4 * c + r] = acfb_pkg::sbox(s[4 * ((c + r) % 4) + r]);
            end
        end

        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] all;
            all = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
            for (int r = 0; r < 4; r++)
            begin
                m[4 * c + r] = t[4 * c + r] ^ all
                    ^ acfb_pkg::xtime(t[4 * c + r] ^ t[4 * c + ((r + 1) % 4)]);
            end
        end

        g[0] = acfb_pkg::sbox(k[13]) ^ rcon;
        g[1] = acfb_pkg::sbox(k[14]);
        g[2] = acfb_pkg::sbox(k[15]);
        g[3] = acfb_pkg::sbox(k[12]);
        for (int i = 0; i < 4; i++)
        begin
            kn[i] = k[i] ^ g[i];
        end
        for (int i = 4; i < 16; i++)
        begin
            kn[i] = k[i] ^ kn[i - 4];
        end

        for (int i = 0; i < 16; i++)
        begin
            rkey_out[127 - 8 * i -: 8] = kn[i];
            blk_out[127 - 8 * i -: 8]  = (last ? t[i] : m[i]) ^ kn[i];
        end
    end

endmodule

// ===== sv/aes128_cfb_cipher.sv =====
// AES-128 in CFB-128 mode. Each request transaction carries one 16-byte block,
// the number of leading valid bytes and a restart flag; restart loads the
// feedback register from the IV before the block. The feedback register is
// encrypted under the configured key to form a keystream, and the valid bytes
// are XORed with it; bytes past the count come out as zero and leave their
// feedback bytes untouched. In encrypt mode the result bytes are fed back, in
// decrypt mode the incoming bytes are. The initial key addition happens as the
// block is accepted, then the single shared round unit runs ten rounds, one
// per cycle, expanding the round keys as it goes, and the cycle that retires
// the result may accept the next block while the result register has room.
// The block is busy during the ten rounds and holds req_stall high; it also
// holds it high while a finished result waits for the result register.
// Configuration writes are registered and must only be issued while no block
// is in flight.
module aes128_cfb_cipher (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  acfb_pkg::acfb_cfg_index_t cfg_index,
    input  logic [63:0]               cfg_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  acfb_pkg::acfb_req_t       req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output acfb_pkg::acfb_rsp_t       rsp
);

    // Configuration registers.
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_high_reg;
    logic [63:0] iv_low_reg;
    logic        decrypt_reg;

    // Sequencer and architectural feedback state.
    acfb_pkg::acfb_state_t state_reg;
    acfb_pkg::acfb_state_t state_next;
    logic [3:0]   round_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] fb_reg;

    // Working data of the block in flight.
    logic [127:0] blk_reg;
    logic [127:0] rkey_reg;
    logic [127:0] data_reg;
    logic [4:0]   count_reg;

    logic                rsp_valid_reg;
    acfb_pkg::acfb_rsp_t rsp_reg;

    logic         accept;
    logic         finish;
    logic         out_free;
    logic         last_round;
    logic [127:0] key_full;
    logic [127:0] result;
    logic [127:0] fb_new;
    logic [127:0] fb_load;
    logic [127:0] blk_round;
    logic [127:0] rkey_round;

    assign key_full   = {key_high_reg, key_low_reg};
    assign last_round = (round_reg == 4'(acfb_pkg::NUM_ROUNDS));
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign accept     = req_valid && !req_stall;

    acfb_round u_round (
        .blk      (blk_reg),
        .rkey     (rkey_reg),
        .rcon     (rcon_reg),
        .last     (last_round),
        .blk_out  (blk_round),
        .rkey_out (rkey_round)
    );

    // Once the rounds are done, blk_reg holds the keystream. Byte j is valid
    // when j is below the count; a count above sixteen covers every byte.
    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            logic [7:0] res_byte;
            logic       byte_ok;
            byte_ok  = (5'(j) < count_reg);
            res_byte = blk_reg[127 - 8 * j -: 8] ^ data_reg[127 - 8 * j -: 8];
            result[127 - 8 * j -: 8] = byte_ok ? res_byte : 8'h00;
            if (byte_ok)
            begin
                fb_new[127 - 8 * j -: 8] = decrypt_reg ? data_reg[127 - 8 * j -: 8] : res_byte;
            end
            else
            begin
                fb_new[127 - 8 * j -: 8] = fb_reg[127 - 8 * j -: 8];
            end
        end
    end

    // A block accepted in the retiring cycle must start from the updated
    // feedback value, so it is bypassed here.
    always_comb
    begin
        if (req.restart)
        begin
            fb_load = {iv_high_reg, iv_low_reg};
        end
        else if (state_reg == acfb_pkg::ST_DONE)
        begin
            fb_load = fb_new;
        end
        else
        begin
            fb_load = fb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acfb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        finish     = 1'b0;
        unique case (state_reg)
            acfb_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = acfb_pkg::ST_RUN;
                end
            end
            acfb_pkg::ST_RUN:
            begin
                if (last_round)
                begin
                    state_next = acfb_pkg::ST_DONE;
                end
            end
            acfb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    req_stall  = 1'b0;
                    state_next = req_valid ? acfb_pkg::ST_RUN : acfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = acfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control, configuration and feedback state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            decrypt_reg   <= 1'b0;
            fb_reg        <= '0;
            round_reg     <= '0;
            rcon_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    acfb_pkg::CFG_KEY_HIGH:     key_high_reg <= cfg_data;
                    acfb_pkg::CFG_KEY_LOW:      key_low_reg  <= cfg_data;
                    acfb_pkg::CFG_IV_HIGH:      iv_high_reg  <= cfg_data;
                    acfb_pkg::CFG_IV_LOW:       iv_low_reg   <= cfg_data;
                    acfb_pkg::CFG_DECRYPT_MODE: decrypt_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                fb_reg <= fb_load;
            end
            else if (finish)
            begin
                fb_reg <= fb_new;
            end

            if (accept)
            begin
                round_reg <= 4'd1;
                rcon_reg  <= 8'h01;
            end
            else if (state_reg == acfb_pkg::ST_RUN)
            begin
                round_reg <= round_reg + 4'd1;
                rcon_reg  <= acfb_pkg::xtime(rcon_reg);
            end

            if (finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; they carry no control meaning and need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg   <= fb_load ^ key_full;
            rkey_reg  <= key_full;
            data_reg  <= {req.data_high, req.data_low};
            count_reg <= req.valid_bytes;
        end
        else if (state_reg == acfb_pkg::ST_RUN)
        begin
            blk_reg  <= blk_round;
            rkey_reg <= rkey_round;
        end

        if (finish)
        begin
            rsp_reg.result_high  <= result[127:64];
            rsp_reg.result_low   <= result[63:0];
            rsp_reg.result_bytes <= count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted block always starts at the first round.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == acfb_pkg::ST_RUN && round_reg == 4'd1))
        else $error("accepted block did not start at round one");

    // While rounds run, the counter stays within the ten AES rounds.
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acfb_pkg::ST_RUN) |-> (round_reg >= 4'd1 && round_reg <= 4'd10))
        else $error("round counter out of range");

    // A new result only appears after the rounds have completed.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == acfb_pkg::ST_DONE))
        else $error("result presented without a completed block");

    // A pending result is never overwritten while stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !finish)
        else $error("result register overwritten while stalled");

endmodule

// ===== verif/testbench.sv =====
module testbench;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    // Ten rounds plus the key addition at acceptance.
    localparam int BLOCK_CYCLES    = 11;
    localparam int TAIL_CYCLES     = 4 * BLOCK_CYCLES;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TIMEOUT_CYCLES  = 1000000;
    localparam int RANDOM_BLOCKS   = 1400;

    // FIPS-197 appendix C.1 example. With the IV set to the plaintext and an
    // all-zero data block, one full CFB block returns the ciphertext itself.
    localparam logic [127:0] FIPS_KEY    = 128'h000102030405060708090a0b0c0d0e0f;
    localparam logic [127:0] FIPS_PLAIN  = 128'h00112233445566778899aabbccddeeff;
    localparam logic [127:0] FIPS_CIPHER = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    acfb_pkg::acfb_cfg_index_t cfg_index;
    logic [63:0]               cfg_data;
    logic                      req_valid;
    logic                      req_stall;
    acfb_pkg::acfb_req_t       req;
    logic                      rsp_valid;
    logic                      rsp_stall;
    acfb_pkg::acfb_rsp_t       rsp;

    aes128_cfb_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the block's registers and its CFB feedback register.
    // The registers only change while nothing is in flight, so the prediction
    // made when a transaction is accepted always sees the settings the block uses.
    logic [127:0] key_shadow;
    logic [127:0] iv_shadow;
    logic         decrypt_shadow;
    logic [127:0] feedback_reg;

    // S-box built locally from the field inverse and the affine map, so the
    // prediction shares no table with the design.
    logic [7:0] sub_bytes_lut [256];

    acfb_pkg::acfb_rsp_t pending_results [$];
    acfb_pkg::acfb_rsp_t last_result;
    acfb_pkg::acfb_rsp_t oldest;

    int  blocks_sent     = 0;
    int  results_checked = 0;
    int  settings_count  = 0;
    int  error_count     = 0;

    // Idle controls shared by the sender, the receiver and the tests.
    bit  sender_gaps     = 1'b1;
    bit  receiver_stalls = 1'b1;
    bit  hold_request    = 1'b0;
    int  stall_left;
    bit  stall_level;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] x;
        prod = 8'h00;
        x    = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                prod ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return prod;
    endfunction

    task automatic build_sub_bytes_lut();
        logic [7:0] inv;
        for (int a = 0; a < 256; a++)
        begin
            inv = 8'h00;
            if (a != 0)
                for (int b = 1; b < 256; b++)
                    if (gf_mul(8'(a), 8'(b)) == 8'h01)
                        inv = 8'(b);
            sub_bytes_lut[a] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                             ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endtask

    // AES-128 encryption of one block. Byte i sits in bits 127-8i down, and
    // byte index is 4 * column + row, as in the standard's state layout.
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] plain);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   rk [16];
        logic [7:0]   rot [4];
        logic [7:0]   rcon;
        logic [7:0]   a0, a1, a2, a3, col_sum;
        logic [127:0] cipher;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = plain[127 - 8 * i -: 8] ^ rk[i];
        end
        rcon = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            // Substitution and row shift: row r of column c comes from column c + r.
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[4 * c + r] = sub_bytes_lut[st[4 * ((c + r) % 4) + r]];
            if (rnd < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = sh[4 * c];
                    a1 = sh[4 * c + 1];
                    a2 = sh[4 * c + 2];
                    a3 = sh[4 * c + 3];
                    col_sum = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ col_sum ^ gf_mul(a0 ^ a1, 8'h02);
                    st[4 * c + 1] = a1 ^ col_sum ^ gf_mul(a1 ^ a2, 8'h02);
                    st[4 * c + 2] = a2 ^ col_sum ^ gf_mul(a2 ^ a3, 8'h02);
                    st[4 * c + 3] = a3 ^ col_sum ^ gf_mul(a3 ^ a0, 8'h02);
                end
            end
            else
                st = sh;
            // Next round key: rotate and substitute the last word, add the round constant.
            rot[0] = sub_bytes_lut[rk[13]] ^ rcon;
            rot[1] = sub_bytes_lut[rk[14]];
            rot[2] = sub_bytes_lut[rk[15]];
            rot[3] = sub_bytes_lut[rk[12]];
            for (int i = 0; i < 4; i++)
                rk[i] ^= rot[i];
            for (int i = 4; i < 16; i++)
                rk[i] ^= rk[i - 4];
            rcon = gf_mul(rcon, 8'h02);
            for (int i = 0; i < 16; i++)
                st[i] ^= rk[i];
        end
        for (int i = 0; i < 16; i++)
            cipher[127 - 8 * i -: 8] = st[i];
        return cipher;
    endfunction

    // One CFB block: returns the expected result and advances the feedback register.
    function automatic acfb_pkg::acfb_rsp_t cfb_next_result(input acfb_pkg::acfb_req_t blk);
        logic [127:0]        keystream;
        logic [127:0]        data;
        logic [127:0]        outcome;
        logic [7:0]          out_byte;
        int                  count;
        acfb_pkg::acfb_rsp_t res;
        if (blk.restart)
            feedback_reg = iv_shadow;
        // Counts above sixteen act as sixteen; the raw count is still echoed.
        count     = (blk.valid_bytes > 5'd16) ? 16 : int'(blk.valid_bytes);
        keystream = aes_encrypt(key_shadow, feedback_reg);
        data      = {blk.data_high, blk.data_low};
        outcome   = '0;
        // Bytes past the count stay zero in the result and keep their feedback byte.
        for (int j = 0; j < count; j++)
        begin
            out_byte = keystream[127 - 8 * j -: 8] ^ data[127 - 8 * j -: 8];
            outcome[127 - 8 * j -: 8] = out_byte;
            feedback_reg[127 - 8 * j -: 8] = decrypt_shadow ? data[127 - 8 * j -: 8] : out_byte;
        end
        res.result_high  = outcome[127:64];
        res.result_low   = outcome[63:0];
        res.result_bytes = blk.valid_bytes;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly short idle stretches with an occasional long one.
    function automatic int random_idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (!sender_gaps || $urandom_range(0, 99) < 55)
            return 0;
        return random_idle_length();
    endfunction

    function automatic logic [63:0] random_word();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic acfb_pkg::acfb_req_t random_block();
        acfb_pkg::acfb_req_t blk;
        blk.data_high   = random_word();
        blk.data_low    = random_word();
        blk.valid_bytes = 5'd16;
        blk.restart     = 1'b0;
        return blk;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------

    task automatic log_failure(input string msg);
        error_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        log_failure($sformatf("%s expected %h actual %h", field, want, got));
    endtask

    // ------------------------------------------------------------------
    // Driving. Every task returns in the time step of a rising edge, right
    // after the edge, so the next task may drive with nonblocking assignments.
    // ------------------------------------------------------------------

    // Offers one transaction, waits for acceptance and records its expected result.
    // The valid is left high so a back-to-back transaction needs no second assignment.
    task automatic send_block(input acfb_pkg::acfb_req_t blk);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= blk;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        last_result = cfb_next_result(blk);
        pending_results = {pending_results, last_result};
        blocks_sent++;
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic wait_until_drained();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_results.size()));
    endtask

    // Leaves the write enable high; configure lowers it after the last write.
    task automatic write_reg(input acfb_pkg::acfb_cfg_index_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            acfb_pkg::CFG_KEY_HIGH:     key_shadow[127:64] = value;
            acfb_pkg::CFG_KEY_LOW:      key_shadow[63:0]   = value;
            acfb_pkg::CFG_IV_HIGH:      iv_shadow[127:64]  = value;
            acfb_pkg::CFG_IV_LOW:       iv_shadow[63:0]    = value;
            acfb_pkg::CFG_DECRYPT_MODE: decrypt_shadow     = value[0];
            default:                    ;
        endcase
    endtask

    // Only called with nothing in flight. The feedback register is not touched,
    // so a stream may carry on across a change of key or direction.
    task automatic configure(input logic [127:0] key, input logic [127:0] iv,
                             input logic mode);
        write_reg(acfb_pkg::CFG_KEY_HIGH, key[127:64]);
        write_reg(acfb_pkg::CFG_KEY_LOW, key[63:0]);
        write_reg(acfb_pkg::CFG_IV_HIGH, iv[127:64]);
        write_reg(acfb_pkg::CFG_IV_LOW, iv[63:0]);
        write_reg(acfb_pkg::CFG_DECRYPT_MODE, {63'd0, mode});
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: zero key, zero feedback, no restart. Also covers an
    // empty transaction and the largest count the field can carry.
    task automatic test_after_reset();
        acfb_pkg::acfb_req_t blk;
        blk = '{data_high: '0, data_low: '0, valid_bytes: 5'd16, restart: 1'b0};
        send_block(blk);
        blk = '{data_high: '1, data_low: '1, valid_bytes: 5'd0, restart: 1'b0};
        send_block(blk);
        blk = random_block();
        blk.valid_bytes = 5'd31;
        send_block(blk);
        wait_until_drained();
    endtask

    task automatic test_known_answer();
        acfb_pkg::acfb_req_t blk;
        configure(FIPS_KEY, FIPS_PLAIN, 1'b0);
        blk = '{data_high: '0, data_low: '0, valid_bytes: 5'd16, restart: 1'b1};
        send_block(blk);
        if ({last_result.result_high, last_result.result_low} !== FIPS_CIPHER)
            log_failure("local AES does not reproduce the published example");
        // A second block chains on the ciphertext just produced.
        send_block(random_block());
        wait_until_drained();
    endtask

    // Partial, empty and oversized counts, a restart in the middle of a stream,
    // and a direction change between transactions without a restart.
    task automatic test_odd_counts();
        acfb_pkg::acfb_req_t blk;
        configure('1, {$urandom, $urandom, $urandom, $urandom}, 1'b0);
        blk = random_block();
        blk.restart     = 1'b1;
        blk.valid_bytes = 5'd1;
        send_block(blk);
        blk = random_block();
        blk.valid_bytes = 5'd15;
        send_block(blk);
        blk = random_block();
        blk.restart     = 1'b1;
        blk.valid_bytes = 5'd0;
        send_block(blk);
        blk = random_block();
        blk.valid_bytes = 5'd17;
        send_block(blk);
        blk = '{data_high: '1, data_low: '1, valid_bytes: 5'd16, restart: 1'b0};
        send_block(blk);
        wait_until_drained();
        configure(key_shadow, iv_shadow, 1'b1);
        blk = random_block();
        blk.valid_bytes = 5'd8;
        send_block(blk);
        send_block(random_block());
        wait_until_drained();
    endtask

    // Encrypts a short stream, then decrypts the ciphertext under the same key
    // and IV; the second pass has to give the plaintext back.
    task automatic test_round_trip();
        logic [127:0]        key, iv;
        logic [127:0]        plain [4];
        logic [127:0]        cipher [4];
        acfb_pkg::acfb_req_t blk;
        key = {$urandom, $urandom, $urandom, $urandom};
        iv  = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < 4; i++)
            plain[i] = {$urandom, $urandom, $urandom, $urandom};
        // The last block is short; its unused bytes are zero so they compare cleanly.
        plain[3][39:0] = '0;
        configure(key, iv, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            blk = '{data_high: plain[i][127:64], data_low: plain[i][63:0],
                    valid_bytes: (i == 3) ? 5'd11 : 5'd16, restart: (i == 0)};
            send_block(blk);
            cipher[i] = {last_result.result_high, last_result.result_low};
        end
        wait_until_drained();
        configure(key, iv, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            blk = '{data_high: cipher[i][127:64], data_low: cipher[i][63:0],
                    valid_bytes: (i == 3) ? 5'd11 : 5'd16, restart: (i == 0)};
            send_block(blk);
            if ({last_result.result_high, last_result.result_low} !== plain[i])
                log_failure($sformatf("round trip block %0d did not return the plaintext", i));
        end
        wait_until_drained();
    endtask

    // The receiver refuses results for a long stretch while the sender keeps
    // offering back to back, so the block fills up and holds its input off.
    task automatic test_output_hold_off();
        acfb_pkg::acfb_req_t blk;
        configure({$urandom, $urandom, $urandom, $urandom},
                  {$urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(0, 1)));
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            blk = random_block();
            blk.restart = (i == 0);
            send_block(blk);
        end
        wait_until_drained();
        sender_gaps = 1'b1;
    endtask

    // Phases of random streams, each under its own settings. The first four
    // phases take the register extremes; every fourth phase runs without idling.
    task automatic test_random_streams(input int total);
        logic [127:0]        key, iv;
        logic                mode;
        int                  phase, left, in_phase, run_len;
        acfb_pkg::acfb_req_t blk;
        phase = 0;
        left  = total;
        while (left > 0)
        begin
            case (phase)
                0:       begin key = '0; iv = '1; mode = 1'b0; end
                1:       begin key = '1; iv = '0; mode = 1'b1; end
                2:       begin key = '1; iv = '1; mode = 1'b0; end
                3:       begin key = '0; iv = '0; mode = 1'b1; end
                default:
                begin
                    key  = {$urandom, $urandom, $urandom, $urandom};
                    iv   = {$urandom, $urandom, $urandom, $urandom};
                    mode = 1'($urandom_range(0, 1));
                end
            endcase
            sender_gaps     = (phase % 4 != 3);
            receiver_stalls = sender_gaps;
            configure(key, iv, mode);
            in_phase = $urandom_range(90, 140);
            if (in_phase > left)
                in_phase = left;
            left -= in_phase;
            while (in_phase > 0)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // Well-formed message: a restart, full blocks, maybe a short tail.
                    run_len = $urandom_range(2, 12);
                    for (int k = 0; k < run_len && in_phase > 0; k++)
                    begin
                        blk = random_block();
                        blk.restart = (k == 0);
                        if (k == run_len - 1 && $urandom_range(0, 1))
                            blk.valid_bytes = 5'($urandom_range(1, 15));
                        send_block(blk);
                        in_phase--;
                    end
                end
                else
                begin
                    // Noise: any count the field holds, restart at random.
                    blk = random_block();
                    blk.valid_bytes = 5'($urandom_range(0, 31));
                    blk.restart     = 1'($urandom_range(0, 1));
                    send_block(blk);
                    in_phase--;
                end
            end
            wait_until_drained();
            phase++;
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall stretches, plus a long hold-off on request that
    // it counts out itself.
    // ------------------------------------------------------------------

    initial
    begin
        rsp_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                rsp_stall <= 1'b0;
                stall_left = 0;
            end
            else if (!receiver_stalls)
                rsp_stall <= 1'b0;
            else
            begin
                if (stall_left == 0)
                begin
                    stall_level = ($urandom_range(0, 99) < 35);
                    stall_left  = random_idle_length();
                end
                rsp_stall <= stall_level;
                stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking: each accepted result transaction against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                log_failure($sformatf("result with nothing pending: %h %h %0d",
                                      rsp.result_high, rsp.result_low, rsp.result_bytes));
            else
            begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (rsp.result_high !== oldest.result_high)
                    report_mismatch("result_high", oldest.result_high, rsp.result_high);
                if (rsp.result_low !== oldest.result_low)
                    report_mismatch("result_low", oldest.result_low, rsp.result_low);
                if (rsp.result_bytes !== oldest.result_bytes)
                    report_mismatch("result_bytes", 64'(oldest.result_bytes),
                                    64'(rsp.result_bytes));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = acfb_pkg::CFG_KEY_HIGH;
        cfg_data       = '0;
        req_valid      = 1'b0;
        req            = '0;
        key_shadow     = '0;
        iv_shadow      = '0;
        decrypt_shadow = 1'b0;
        feedback_reg   = '0;
        build_sub_bytes_lut();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_known_answer();
        test_odd_counts();
        test_round_trip();
        test_output_hold_off();
        test_random_streams(RANDOM_BLOCKS);

        // Let any stray result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d blocks under %0d register settings,",
                 results_checked, blocks_sent, settings_count);
        $display("in both directions with odd counts, restarts and a long output hold-off.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== aes128_cfb_cipher.f =====
sv/acfb_pkg.sv
sv/acfb_round.sv
sv/aes128_cfb_cipher.sv
verif/testbench.sv
